// ===== rtl/spq_pkg.sv =====
// shared types, codes and defaults of the sorted priority queue
package spq_pkg;

	localparam int QUEUE_DEPTH_DEF  = 16;
	localparam int KEY_BITS_DEF     = 16;
	localparam int PAYLOAD_BITS_DEF = 32;

	// request action codes
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	// order mode codes
	localparam logic ORDER_MIN_FIRST = 1'b0;
	localparam logic ORDER_MAX_FIRST = 1'b1;

	// result status codes
	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_POP_EMPTY  = 2'd1;
	localparam logic [1:0] STAT_PUSH_FULL  = 2'd2;

	// shift control broadcast to every cell
	typedef struct packed {
		logic push_en;
		logic pop_en;
		logic order;
	} spq_ctrl_t;

endpackage

// ===== rtl/spq_req_if.sv =====
// request channel of the sorted priority queue
interface spq_req_if #(
	parameter int KEY_BITS     = spq_pkg::KEY_BITS_DEF,
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	logic                    action;
	logic [KEY_BITS-1:0]     key;
	logic [PAYLOAD_BITS-1:0] payload;

	modport source (output valid, action, key, payload, input ready);
	modport sink   (input valid, action, key, payload, output ready);
endinterface

// ===== rtl/spq_rsp_if.sv =====
// result channel of the sorted priority queue
interface spq_rsp_if #(
	parameter int KEY_BITS     = spq_pkg::KEY_BITS_DEF,
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
	parameter int CNT_BITS     = $clog2(spq_pkg::QUEUE_DEPTH_DEF + 1)
);
	logic                    valid;
	logic                    ready;
	logic [1:0]              status;
	logic [KEY_BITS-1:0]     out_key;
	logic [PAYLOAD_BITS-1:0] out_payload;
	logic [CNT_BITS-1:0]     entry_count;

	modport source (output valid, status, out_key, out_payload, entry_count, input ready);
	modport sink   (input valid, status, out_key, out_payload, entry_count, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
// one storage cell of the sorted shift chain
module spq_cell #(
	parameter int KEY_BITS     = spq_pkg::KEY_BITS_DEF,
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                    clk,
	input  spq_pkg::spq_ctrl_t      ctrl,
	input  logic                    occupied,
	input  logic [KEY_BITS-1:0]     new_key,
	input  logic [PAYLOAD_BITS-1:0] new_payload,
	input  logic                    left_beat,
	input  logic [KEY_BITS-1:0]     left_key,
	input  logic [PAYLOAD_BITS-1:0] left_payload,
	input  logic [KEY_BITS-1:0]     right_key,
	input  logic [PAYLOAD_BITS-1:0] right_payload,
	output logic                    beat,
	output logic [KEY_BITS-1:0]     key,
	output logic [PAYLOAD_BITS-1:0] payload
);
	import spq_pkg::*;

	logic [KEY_BITS-1:0]     key_q;
	logic [PAYLOAD_BITS-1:0] payload_q;
	logic                    beat_here;

	// new entry beats the entry held in this cell
	always_comb begin
		if (!occupied) begin
			beat_here = 1'b1;
		end else if (ctrl.order == ORDER_MAX_FIRST) begin
			beat_here = new_key > key_q;
		end else begin
			beat_here = new_key < key_q;
		end
	end

	// new entry belongs at or before this cell; carried down the row so only
	// the first beating cell takes the new entry, even after an order change
	assign beat = left_beat || beat_here;

	always_ff @(posedge clk) begin
		if (ctrl.push_en) begin
			if (left_beat) begin
				key_q     <= left_key;
				payload_q <= left_payload;
			end else if (beat_here) begin
				key_q     <= new_key;
				payload_q <= new_payload;
			end
		end else if (ctrl.pop_en) begin
			key_q     <= right_key;
			payload_q <= right_payload;
		end
	end

	assign key     = key_q;
	assign payload = payload_q;
endmodule

// ===== rtl/sorted_priority_queue_unit.sv =====
// top level of the sorted priority queue: cell chain, entry count and result register
//
// Sorted priority queue built as a row of QUEUE_DEPTH cells, head at cell 0.
// A push request compares its key against every cell at once; the cell at the
// insertion point loads the new entry and every cell behind it takes its left
// neighbour's contents, so equal keys keep arrival order. A pop request shifts
// every cell one place towards the head and returns the old head. Each request
// updates the cell row while its result is captured in an output register,
// so one request can be accepted every cycle while the result side keeps up;
// req.ready drops only while a result waits untaken. order_mode (cfg_wdata on
// cfg_we) selects smallest-first (0) or largest-first (1) and should only change
// while the queue is idle. Pushes into a full queue are dropped with status 2,
// pops from an empty queue give status 1; popped key and payload read zero
// otherwise.
module sorted_priority_queue_unit #(
	parameter int QUEUE_DEPTH  = spq_pkg::QUEUE_DEPTH_DEF,
	parameter int KEY_BITS     = spq_pkg::KEY_BITS_DEF,
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	spq_req_if.sink    req,
	spq_rsp_if.source  rsp
);
	import spq_pkg::*;

	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	// configuration and occupancy
	logic                order_q;
	logic [CNT_BITS-1:0] count_q;

	// result register
	logic                    rsp_valid_q;
	logic [1:0]              status_q;
	logic [KEY_BITS-1:0]     out_key_q;
	logic [PAYLOAD_BITS-1:0] out_payload_q;
	logic [CNT_BITS-1:0]     entry_count_q;

	// cell row wiring
	logic                    beat_w    [QUEUE_DEPTH];
	logic [KEY_BITS-1:0]     key_w     [QUEUE_DEPTH];
	logic [PAYLOAD_BITS-1:0] payload_w [QUEUE_DEPTH];

	logic                accept;
	logic                full;
	logic                empty;
	logic                is_push;
	spq_ctrl_t           ctrl;
	logic [CNT_BITS-1:0] next_count;

	// a waiting result blocks only if the sink is not taking it
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign full    = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign is_push = (req.action == ACT_PUSH);

	assign ctrl.push_en = accept && is_push && !full;
	assign ctrl.pop_en  = accept && !is_push && !empty;
	assign ctrl.order   = order_q;

	always_comb begin
		next_count = count_q;
		if (ctrl.push_en) begin
			next_count = count_q + CNT_BITS'(1);
		end else if (ctrl.pop_en) begin
			next_count = count_q - CNT_BITS'(1);
		end
	end

	// the row of cells; occupancy comes from the count, not from per-cell flags
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                    occ;
		logic                    lb;
		logic [KEY_BITS-1:0]     lk;
		logic [PAYLOAD_BITS-1:0] lp;
		logic [KEY_BITS-1:0]     rk;
		logic [PAYLOAD_BITS-1:0] rp;

		assign occ = (CNT_BITS'(i) < count_q);

		if (i == 0) begin : g_head
			// nothing sits left of the head, so it never shifts in from the left
			assign lb = 1'b0;
			assign lk = req.key;
			assign lp = req.payload;
		end else begin : g_mid
			assign lb = beat_w[i-1];
			assign lk = key_w[i-1];
			assign lp = payload_w[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			// tail contents after a pop are beyond the count and never read
			assign rk = key_w[i];
			assign rp = payload_w[i];
		end else begin : g_body
			assign rk = key_w[i+1];
			assign rp = payload_w[i+1];
		end

		spq_cell #(
			.KEY_BITS     (KEY_BITS),
			.PAYLOAD_BITS (PAYLOAD_BITS)
		) u_cell (
			.clk           (clk),
			.ctrl          (ctrl),
			.occupied      (occ),
			.new_key       (req.key),
			.new_payload   (req.payload),
			.left_beat     (lb),
			.left_key      (lk),
			.left_payload  (lp),
			.right_key     (rk),
			.right_payload (rp),
			.beat          (beat_w[i]),
			.key           (key_w[i]),
			.payload       (payload_w[i])
		);
	end

	// configuration register and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_MIN_FIRST;
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				order_q <= cfg_wdata;
			end
			count_q <= next_count;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result fields, captured alongside the cell update
	always_ff @(posedge clk) begin
		if (accept) begin
			entry_count_q <= next_count;
			out_key_q     <= '0;
			out_payload_q <= '0;
			if (is_push) begin
				status_q <= full ? STAT_PUSH_FULL : STAT_OK;
			end else if (empty) begin
				status_q <= STAT_POP_EMPTY;
			end else begin
				status_q      <= STAT_OK;
				out_key_q     <= key_w[0];
				out_payload_q <= payload_w[0];
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.out_key     = out_key_q;
	assign rsp.out_payload = out_payload_q;
	assign rsp.entry_count = entry_count_q;
endmodule

// ===== tb/spq_checker.sv =====
// watcher of the queue channels: predicts every result and compares it on arrival
`timescale 1ns / 1ps

module spq_checker
	import spq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	spq_req_if        req,
	spq_rsp_if        rsp,
	output int        fail_count,
	output int        outstanding
);

	localparam int DEPTH    = QUEUE_DEPTH_DEF;
	localparam int KW       = KEY_BITS_DEF;
	localparam int PW       = PAYLOAD_BITS_DEF;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH_DEF + 1);

	typedef struct packed {
		logic [1:0]          status;
		logic [KW-1:0]       out_key;
		logic [PW-1:0]       out_payload;
		logic [CNT_BITS-1:0] entry_count;
	} spq_result_t;

	// mirror of the cell row, head at index 0
	logic [KW-1:0] held_keys [DEPTH];
	logic [PW-1:0] held_payloads [DEPTH];
	int            held_count = 0;
	logic          order = ORDER_MIN_FIRST;

	spq_result_t   awaited_results [$];

	initial begin
		fail_count  = 0;
		outstanding = 0;
	end

	function automatic logic outranks(input logic [KW-1:0] a, input logic [KW-1:0] b);
		return (order == ORDER_MAX_FIRST) ? (a > b) : (a < b);
	endfunction

	// applies one request to the mirror and returns the result it should give
	function automatic spq_result_t apply_queue_op(input logic act, input logic [KW-1:0] k,
			input logic [PW-1:0] p);
		spq_result_t res;
		int          slot;
		res = '0;
		if (act == ACT_PUSH) begin
			if (held_count >= DEPTH) begin
				res.status = STAT_PUSH_FULL;
			end else begin
				slot = held_count;
				for (int i = 0; i < held_count; i++) begin
					if (outranks(k, held_keys[i])) begin
						slot = i;
						break;
					end
				end
				for (int i = held_count; i > slot; i--) begin
					held_keys[i]     = held_keys[i-1];
					held_payloads[i] = held_payloads[i-1];
				end
				held_keys[slot]     = k;
				held_payloads[slot] = p;
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				res.status = STAT_POP_EMPTY;
			end else begin
				res.out_key     = held_keys[0];
				res.out_payload = held_payloads[0];
				for (int i = 1; i < held_count; i++) begin
					held_keys[i-1]     = held_keys[i];
					held_payloads[i-1] = held_payloads[i];
				end
				held_count--;
			end
		end
		res.entry_count = CNT_BITS'(held_count);
		return res;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want_v,
				got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		spq_result_t got, want;
		if (!arst_n) begin
			held_count = 0;
			order      = ORDER_MIN_FIRST;
			awaited_results.delete();
			outstanding <= 0;
		end else begin
			// a request at the same edge as a register write still sees the old order
			if (req.valid && req.ready)
				awaited_results.push_back(apply_queue_op(req.action, req.key, req.payload));
			if (cfg_we)
				order = cfg_wdata;
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.status, rsp.out_key, rsp.out_payload, rsp.entry_count};
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					check_field("status", 32'(want.status), 32'(got.status));
					check_field("out_key", 32'(want.out_key), 32'(got.out_key));
					check_field("out_payload", 32'(want.out_payload), 32'(got.out_payload));
					check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
				end
			end
			outstanding <= awaited_results.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// top of the queue testbench: clock, reset, stimulus, result-side stalls and verdict
`timescale 1ns / 1ps

module tb;
	import spq_pkg::*;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 9;
	localparam int LIMIT_CYCLES = 300000;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 220;
	localparam int HOLD_CYCLES  = 90;
	localparam int SETTLE       = 8;
	localparam int DEPTH        = QUEUE_DEPTH_DEF;
	localparam int KW           = KEY_BITS_DEF;
	localparam int PW           = PAYLOAD_BITS_DEF;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic cfg_wdata;

	int fail_count;
	int outstanding;

	// idling switches shared by the two sides
	bit idle_on   = 1'b1;   // cleared for the closing phase
	int gap_pct   = 0;      // chance of a sender gap before a request
	bit long_hold = 1'b0;   // asks the result side for one long stall

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	sorted_priority_queue_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	spq_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// hard stop in case the queue hangs
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("** sorted_priority_queue_unit: FAILED **");
		$finish;
	end

	// offers one request and returns at the edge that takes it; valid stays high
	// so back-to-back requests leave no bubble
	task automatic send_request(input logic act, input logic [KW-1:0] k,
			input logic [PW-1:0] p);
		if (idle_on && $urandom_range(1, 100) <= gap_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.action  <= act;
		req_ch.key     <= k;
		req_ch.payload <= p;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// empties the store, drops valid and waits for every result to come back
	task automatic close_phase();
		repeat (DEPTH + 1) send_request(ACT_POP, KW'($urandom), PW'($urandom));
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_order(input logic mode);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// random traffic in bursts that lean towards filling, draining or neither,
	// so the full and empty corners come up often
	task automatic run_random(input int n_items);
		int            left;
		int            burst;
		int            push_pct;
		logic [KW-1:0] k;
		logic [PW-1:0] p;
		left = n_items;
		while (left > 0) begin
			burst = $urandom_range(8, 40);
			if (burst > left)
				burst = left;
			case ($urandom_range(0, 2))
				0: push_pct = 80;
				1: push_pct = 50;
				default: push_pct = 25;
			endcase
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 15;
				default: gap_pct = 40;
			endcase
			repeat (burst) begin
				// narrow keys give plenty of ties, some hit the ends of the range, the rest are random
				case ($urandom_range(0, 3))
					0: k = KW'($urandom_range(0, 7));
					1: k = ($urandom_range(0, 1) != 0) ? {KW{1'b1}} - KW'($urandom_range(0, 1))
					                                   : KW'($urandom_range(0, 1));
					default: k = KW'($urandom);
				endcase
				case ($urandom_range(0, 15))
					0: p = '0;
					1: p = '1;
					default: p = PW'($urandom);
				endcase
				if ($urandom_range(1, 100) <= push_pct)
					send_request(ACT_PUSH, k, p);
				else
					send_request(ACT_POP, k, p);
			end
			left -= burst;
		end
	endtask

	// result side: short random stalls, ready runs of varied length, and one long
	// hold-off on request so the output register backs up into the request side
	initial begin : result_side
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		req_ch.valid   = 1'b0;
		req_ch.action  = ACT_PUSH;
		req_ch.key     = '0;
		req_ch.payload = '0;
		cfg_we         = 1'b0;
		cfg_wdata      = ORDER_MIN_FIRST;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, smallest key first
		write_order(ORDER_MIN_FIRST);
		gap_pct = 20;
		send_request(ACT_POP, '0, '0);                       // pop from empty store
		send_request(ACT_PUSH, 16'h8000, 32'h0000_0001);
		send_request(ACT_PUSH, 16'h8000, 32'h0000_0002);     // tie keeps arrival order
		send_request(ACT_PUSH, 16'h0000, 32'h0000_0000);     // lowest key, zero payload
		send_request(ACT_PUSH, 16'hFFFF, 32'hFFFF_FFFF);     // highest key, all-ones payload
		send_request(ACT_PUSH, 16'h8000, 32'h0000_0003);     // third of the tie
		send_request(ACT_PUSH, 16'h0001, 32'hA5A5_5A5A);
		send_request(ACT_PUSH, 16'hFFFE, 32'h5A5A_A5A5);
		for (int i = 0; i < 9; i++)
			send_request(ACT_PUSH, KW'(i * 16'h1111), PW'($urandom));
		send_request(ACT_PUSH, 16'h4000, 32'h1234_5678);     // store full, dropped
		repeat (4) send_request(ACT_POP, '0, '0);
		close_phase();

		// random phases, alternating the service order between its two settings
		for (int phase = 0; phase < PHASES; phase++) begin
			idle_on = (phase < PHASES - 1);
			if (phase == 1)
				long_hold = 1'b1;
			write_order((phase % 2 == 0) ? ORDER_MAX_FIRST : ORDER_MIN_FIRST);
			run_random(PHASE_ITEMS);
			close_phase();
		end

		// a stray result after the last one would show up here
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("** sorted_priority_queue_unit: PASSED **");
		else
			$display("** sorted_priority_queue_unit: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/spq_pkg.sv
rtl/spq_req_if.sv
rtl/spq_rsp_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unit.sv
tb/spq_checker.sv
tb/tb.sv
